[design/gaa_pkg.sv]
// ----------------------------------------------------------------------------
// gaa_pkg
// Shared types, codes and constants of the gravity acceleration accumulator.
// ----------------------------------------------------------------------------
package gaa_pkg;

  localparam int unsigned POS_W   = 48;
  localparam int unsigned MASS_W  = 48;
  localparam int unsigned RANGE_W = 47;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned ACC_W   = 64;

  // G scaled by 2^64, rounded
  localparam logic [30:0] GQ64 = 31'd1230634299;

  localparam int unsigned OP_W = 4;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd0;
  localparam logic [OP_W-1:0] OP_MUL_XX = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL_YY = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL_RR = 4'd3;
  localparam logic [OP_W-1:0] OP_SQRT   = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL_R2 = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL_R3 = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL_MG = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL_NX = 4'd8;
  localparam logic [OP_W-1:0] OP_MUL_NY = 4'd9;
  localparam logic [OP_W-1:0] OP_DIV_X  = 4'd10;
  localparam logic [OP_W-1:0] OP_DIV_Y  = 4'd11;
  localparam logic [OP_W-1:0] OP_HIT    = 4'd12;
  localparam logic [OP_W-1:0] OP_EMIT   = 4'd13;

  typedef struct packed {
    logic signed [POS_W-1:0] self_x;
    logic signed [POS_W-1:0] self_y;
    logic                    self_static;
    logic signed [POS_W-1:0] other_x;
    logic signed [POS_W-1:0] other_y;
    logic [MASS_W-1:0]       other_mass;
    logic                    other_static;
    logic                    other_is_self;
    logic [IDX_W-1:0]        other_index;
    logic                    last;
  } gaa_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic                    accel_written;
    logic                    self_destroyed;
    logic                    other_destroyed;
    logic [IDX_W-1:0]        destroyed_index;
  } gaa_out_t;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } gaa_cmd_t;

  typedef struct packed {
    logic done;
    logic skip;
    logic coll;
    logic rzero;
    logic last;
  } gaa_stat_t;

endpackage

[design/gaa_datapath.sv]
// ----------------------------------------------------------------------------
// gaa_datapath
// Shared 100x8 digit multiplier, bit-serial square root, radix-2 divider,
// saturating accumulators and the result register.
// ----------------------------------------------------------------------------
module gaa_datapath import gaa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gaa_cmd_t             cmd_i,
  input  gaa_in_t              in_i,
  input  logic                 cfg_valid_i,
  input  logic [RANGE_W-1:0]   cfg_data_i,
  output gaa_stat_t            stat_o,
  output gaa_out_t             out_o
);

  // control state
  logic                   mul_run_q, sq_run_q, div_run_q;
  logic [5:0]             cnt_q;
  logic [OP_W-1:0]        op_q;
  logic [ACC_W-1:0]       sum_x_q, sum_y_q;
  logic                   collided_q, hit_other_q;
  logic [IDX_W-1:0]       hit_index_q;
  logic [RANGE_W-1:0]     range_q;

  // payload
  logic [48:0]            ax_q, ay_q;
  logic                   negx_q, negy_q;
  logic [MASS_W-1:0]      mass_q;
  logic                   self_static_q, other_static_q, is_self_q, last_q;
  logic [IDX_W-1:0]       index_q;
  logic [99:0]            a_q;
  logic [55:0]            b_q;
  logic [155:0]           prod_q;
  logic [97:0]            sxx_q;
  logic [99:0]            s_q;
  logic [93:0]            rr_q;
  logic [51:0]            srem_q;
  logic [49:0]            root_q;
  logic [99:0]            r2_q;
  logic [149:0]           den_q;
  logic [78:0]            mg_q;
  logic [135:0]           num_q;
  logic [149:0]           rem_q;
  logic [62:0]            quo_q;
  logic                   sat_q;
  gaa_out_t               out_q;

  logic [48:0]            dx_w, dy_w;
  logic [99:0]            mul_a_w;
  logic [49:0]            mul_b_w;
  logic [107:0]           pp_w;
  logic [155:0]           prod_d;
  logic [51:0]            srem_sh, trial_w, srem_d;
  logic                   sq_ge;
  logic [150:0]           dt_w;
  logic                   d_ge;
  logic [149:0]           rem_d;
  logic [62:0]            quo_d, mag_w;
  logic                   done_w;
  logic                   written_w;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [62:0] m,
                                               input logic neg);
    logic [ACC_W:0] t;
    t = neg ? ({a[ACC_W-1], a} - {2'b00, m}) : ({a[ACC_W-1], a} + {2'b00, m});
    if (t[ACC_W] != t[ACC_W-1]) begin
      return t[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return t[ACC_W-1:0];
  endfunction

  always_comb begin
    dx_w = {in_i.other_x[POS_W-1], in_i.other_x} - {in_i.self_x[POS_W-1], in_i.self_x};
    dy_w = {in_i.other_y[POS_W-1], in_i.other_y} - {in_i.self_y[POS_W-1], in_i.self_y};
  end

  always_comb begin
    mul_a_w = '0;
    mul_b_w = '0;
    unique case (cmd_i.op)
      OP_MUL_XX: begin mul_a_w = {51'b0, ax_q};    mul_b_w = {1'b0, ax_q};    end
      OP_MUL_YY: begin mul_a_w = {51'b0, ay_q};    mul_b_w = {1'b0, ay_q};    end
      OP_MUL_RR: begin mul_a_w = {53'b0, range_q}; mul_b_w = {3'b0, range_q}; end
      OP_MUL_R2: begin mul_a_w = {50'b0, root_q};  mul_b_w = root_q;          end
      OP_MUL_R3: begin mul_a_w = r2_q;             mul_b_w = root_q;          end
      OP_MUL_MG: begin mul_a_w = {52'b0, mass_q};  mul_b_w = {19'b0, GQ64};   end
      OP_MUL_NX: begin mul_a_w = {21'b0, mg_q};    mul_b_w = {1'b0, ax_q};    end
      OP_MUL_NY: begin mul_a_w = {21'b0, mg_q};    mul_b_w = {1'b0, ay_q};    end
      default: begin end
    endcase
  end

  // multiplier step: one 8-bit digit of b, MSB first
  assign pp_w   = a_q * b_q[55:48];
  assign prod_d = {prod_q[147:0], 8'b0} + {48'b0, pp_w};

  // square root step
  assign srem_sh = {srem_q[49:0], s_q[99:98]};
  assign trial_w = {root_q, 2'b01};
  assign sq_ge   = srem_sh >= trial_w;
  assign srem_d  = sq_ge ? (srem_sh - trial_w) : srem_sh;

  // divider step
  assign dt_w  = {rem_q, num_q[62]};
  assign d_ge  = dt_w >= {1'b0, den_q};
  assign rem_d = d_ge ? 150'(dt_w - {1'b0, den_q}) : dt_w[149:0];
  assign quo_d = {quo_q[61:0], d_ge};
  assign mag_w = sat_q ? {63{1'b1}} : quo_d;

  assign done_w = (mul_run_q && cnt_q == 6'd1) || (sq_run_q && cnt_q == 6'd1) ||
                  (div_run_q && (sat_q || cnt_q == 6'd1));

  assign written_w = !self_static_q && !collided_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_run_q   <= 1'b0;
      sq_run_q    <= 1'b0;
      div_run_q   <= 1'b0;
      cnt_q       <= '0;
      op_q        <= OP_LOAD;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      collided_q  <= 1'b0;
      hit_other_q <= 1'b0;
      hit_index_q <= '0;
      range_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        range_q <= cfg_data_i;
      end
      if (mul_run_q || sq_run_q || div_run_q) begin
        cnt_q <= cnt_q - 6'd1;
      end
      if (done_w) begin
        mul_run_q <= 1'b0;
        sq_run_q  <= 1'b0;
        div_run_q <= 1'b0;
        if (div_run_q) begin
          if (op_q == OP_DIV_X) begin
            sum_x_q <= sat_add(sum_x_q, mag_w, negx_q);
          end else begin
            sum_y_q <= sat_add(sum_y_q, mag_w, negy_q);
          end
        end
      end
      if (cmd_i.start) begin
        op_q <= cmd_i.op;
        unique case (cmd_i.op) inside
          OP_MUL_XX, OP_MUL_YY, OP_MUL_RR, OP_MUL_R2, OP_MUL_R3,
          OP_MUL_MG, OP_MUL_NX, OP_MUL_NY: begin
            mul_run_q <= 1'b1;
            cnt_q     <= 6'd7;
          end
          OP_SQRT: begin
            sq_run_q <= 1'b1;
            cnt_q    <= 6'd50;
          end
          OP_DIV_X, OP_DIV_Y: begin
            div_run_q <= 1'b1;
            cnt_q     <= 6'd63;
          end
          OP_HIT: begin
            collided_q  <= 1'b1;
            hit_other_q <= !other_static_q;
            hit_index_q <= other_static_q ? '0 : index_q;
          end
          OP_EMIT: begin
            sum_x_q     <= '0;
            sum_y_q     <= '0;
            collided_q  <= 1'b0;
            hit_other_q <= 1'b0;
            hit_index_q <= '0;
          end
          default: begin end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_run_q) begin
      prod_q <= prod_d;
      b_q    <= {b_q[47:0], 8'b0};
      if (done_w) begin
        unique case (op_q)
          OP_MUL_XX: sxx_q  <= prod_d[97:0];
          OP_MUL_YY: s_q    <= {2'b0, sxx_q} + prod_d[99:0];
          OP_MUL_RR: rr_q   <= prod_d[93:0];
          OP_MUL_R2: r2_q   <= prod_d[99:0];
          OP_MUL_R3: den_q  <= prod_d[149:0];
          OP_MUL_MG: mg_q   <= prod_d[78:0];
          default:   num_q  <= {prod_d[127:0], 8'b0};
        endcase
      end
    end
    if (sq_run_q) begin
      srem_q <= srem_d;
      root_q <= {root_q[48:0], sq_ge};
      s_q    <= {s_q[97:0], 2'b00};
    end
    if (div_run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      num_q <= {num_q[134:0], 1'b0};
    end
    if (cmd_i.start) begin
      unique case (cmd_i.op) inside
        OP_LOAD: begin
          negx_q         <= dx_w[48];
          negy_q         <= dy_w[48];
          ax_q           <= dx_w[48] ? (~dx_w + 49'd1) : dx_w;
          ay_q           <= dy_w[48] ? (~dy_w + 49'd1) : dy_w;
          mass_q         <= in_i.other_mass;
          self_static_q  <= in_i.self_static;
          other_static_q <= in_i.other_static;
          is_self_q      <= in_i.other_is_self;
          index_q        <= in_i.other_index;
          last_q         <= in_i.last;
        end
        OP_MUL_XX, OP_MUL_YY, OP_MUL_RR, OP_MUL_R2, OP_MUL_R3,
        OP_MUL_MG, OP_MUL_NX, OP_MUL_NY: begin
          a_q    <= mul_a_w;
          b_q    <= {6'b0, mul_b_w};
          prod_q <= '0;
        end
        OP_SQRT: begin
          srem_q <= '0;
          root_q <= '0;
        end
        OP_DIV_X, OP_DIV_Y: begin
          rem_q <= {77'b0, num_q[135:63]};
          sat_q <= {77'b0, num_q[135:63]} >= den_q;
          quo_q <= '0;
        end
        OP_EMIT: begin
          out_q.accel_x         <= written_w ? sum_x_q : '0;
          out_q.accel_y         <= written_w ? sum_y_q : '0;
          out_q.accel_written   <= written_w;
          out_q.self_destroyed  <= collided_q;
          out_q.other_destroyed <= hit_other_q;
          out_q.destroyed_index <= hit_other_q ? hit_index_q : '0;
        end
        default: begin end
      endcase
    end
  end

  assign stat_o.done  = done_w;
  assign stat_o.skip  = collided_q || self_static_q || is_self_q;
  assign stat_o.coll  = s_q < {6'b0, rr_q};
  assign stat_o.rzero = root_q == '0;
  assign stat_o.last  = last_q;
  assign out_o        = out_q;

endmodule

[design/gaa_ctrl.sv]
// ----------------------------------------------------------------------------
// gaa_ctrl
// Sequencer: steps the datapath through one body and owns both handshakes.
// ----------------------------------------------------------------------------
module gaa_ctrl import gaa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  gaa_stat_t stat_i,
  output gaa_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_XX   = 4'd2;
  localparam logic [3:0] S_YY   = 4'd3;
  localparam logic [3:0] S_RR   = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_R2   = 4'd7;
  localparam logic [3:0] S_R3   = 4'd8;
  localparam logic [3:0] S_MG   = 4'd9;
  localparam logic [3:0] S_NX   = 4'd10;
  localparam logic [3:0] S_DX   = 4'd11;
  localparam logic [3:0] S_NY   = 4'd12;
  localparam logic [3:0] S_DY   = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0]      state_q, state_d, nxt_w;
  logic            wait_q, wait_d;
  logic            out_valid_q, out_valid_d;
  logic            unit_w;
  logic [OP_W-1:0] op_w;
  gaa_cmd_t        cmd_w;

  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    unit_w      = 1'b0;
    op_w        = OP_LOAD;
    nxt_w       = S_IDLE;
    cmd_w.start = 1'b0;
    cmd_w.op    = OP_LOAD;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_w.start = 1'b1;
          cmd_w.op    = OP_LOAD;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: state_d = stat_i.skip ? S_FIN : S_XX;
      S_XX:   begin unit_w = 1'b1; op_w = OP_MUL_XX; nxt_w = S_YY;   end
      S_YY:   begin unit_w = 1'b1; op_w = OP_MUL_YY; nxt_w = S_RR;   end
      S_RR:   begin unit_w = 1'b1; op_w = OP_MUL_RR; nxt_w = S_CMP;  end
      S_CMP: begin
        if (stat_i.coll) begin
          cmd_w.start = 1'b1;
          cmd_w.op    = OP_HIT;
          state_d     = S_FIN;
        end else begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin unit_w = 1'b1; op_w = OP_SQRT; nxt_w = S_R2; end
      S_R2: begin
        if (!wait_q && stat_i.rzero) begin
          state_d = S_FIN;
        end else begin
          unit_w = 1'b1; op_w = OP_MUL_R2; nxt_w = S_R3;
        end
      end
      S_R3:   begin unit_w = 1'b1; op_w = OP_MUL_R3; nxt_w = S_MG;  end
      S_MG:   begin unit_w = 1'b1; op_w = OP_MUL_MG; nxt_w = S_NX;  end
      S_NX:   begin unit_w = 1'b1; op_w = OP_MUL_NX; nxt_w = S_DX;  end
      S_DX:   begin unit_w = 1'b1; op_w = OP_DIV_X;  nxt_w = S_NY;  end
      S_NY:   begin unit_w = 1'b1; op_w = OP_MUL_NY; nxt_w = S_DY;  end
      S_DY:   begin unit_w = 1'b1; op_w = OP_DIV_Y;  nxt_w = S_FIN; end
      S_FIN: begin
        if (!stat_i.last) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_w.start = 1'b1;
          cmd_w.op    = OP_EMIT;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (unit_w) begin
      cmd_w.op = op_w;
      if (!wait_q) begin
        cmd_w.start = 1'b1;
        wait_d      = 1'b1;
      end else if (stat_i.done) begin
        wait_d  = 1'b0;
        state_d = nxt_w;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_w.start && cmd_w.op == OP_EMIT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd_w;

endmodule

[design/gravity_accel_accumulator_core.sv]
// ----------------------------------------------------------------------------
// gravity_accel_accumulator_core
// 2-D gravitational acceleration on one target, summed over a run of bodies.
// Work per body: a contributing body runs the square root (50 steps) and two
//   divisions of up to 63 steps each on the shared radix-2 divider; a skipped
//   body or a collision ends early. One body in flight at a time.
// Results are registered once the last body finishes; one may wait in the
//   output register while the next run is taken in.
// Reset: async active low; clears sums, collision state, range and handshakes.
// ----------------------------------------------------------------------------
module gravity_accel_accumulator_core import gaa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gaa_in_t            in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gaa_out_t           out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RANGE_W-1:0] cfg_data_i
);

  gaa_cmd_t  cmd;
  gaa_stat_t stat;

  assign cfg_ready_o = 1'b1;

  gaa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gaa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .out_o       (out_o)
  );

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while body in flight");

  a_written_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.accel_written |-> !out_o.self_destroyed)
    else $error("acceleration written after collision");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.other_destroyed |-> out_o.destroyed_index == '0)
    else $error("stale destroyed index");

endmodule
